// File: src/jsu_pkg.sv
// Shared types, constants and helpers for the JSON string unescaper.
// No dependencies; used by every module of the unit.
package jsu_pkg;

  localparam int unsigned LenW = 16;

  localparam logic [LenW-1:0] CapReset = LenW'(64);
  localparam logic [LenW-1:0] MinHexLeft = LenW'(5);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChU      = 8'h75;
  localparam logic [7:0] ChNul    = 8'h00;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOMEM     = 2'd1,
    ST_NOINPUT   = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  // Parse mode, one-hot
  typedef enum logic [2:0] {
    MODE_PLAIN = 3'b001,
    MODE_ESC   = 3'b010,
    MODE_HEX   = 3'b100
  } mode_e;

  typedef struct packed {
    mode_e           mode;
    logic [1:0]      hex_cnt;
    logic [11:0]     hex_acc;
    logic [LenW-1:0] space;
  } state_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       done_res;
    status_e    status;
    logic       last;
  } res_t;

  // Hex digit value; bit 4 flags a byte that is not a hex digit
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

// File: src/json_string_unescaper_unit.sv
// JSON string unescaper top level: input register, step logic, result queue.
// A result passes the input register and then the result queue; back-pressure can hold it in either.
// Throughput: one byte per cycle while the result queue has room; a byte that yields two results (a unicode
//   escape with a nonzero high byte) waits until the result queue is empty or
//   its one entry leaves in the same cycle.
// Reset clears the queue and input stage, sets capacity to 64 and plain mode.
// Depends on jsu_pkg, jsu_step and jsu_outq.
module json_string_unescaper_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,   // dest_capacity
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] in_byte, [23:8] bytes_left
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] out_byte
  output logic [3:0]  m_axis_tuser,  // [0] byte_valid, [1] done_res, [3:2] status
  output logic        m_axis_tlast   // last
);

  logic                     in_vld_q, in_vld_d;
  logic [7:0]               in_byte_q;
  logic [jsu_pkg::LenW-1:0] in_left_q;
  logic [jsu_pkg::LenW-1:0] cap_q;
  jsu_pkg::state_t          st_q, st_next;
  logic [1:0]               nres, room, push;
  jsu_pkg::res_t            r0, r1, head;
  logic                     go, s_xfer;

  jsu_step u_step (
    .st_i        (st_q),
    .cap_i       (cap_q),
    .in_byte_i   (in_byte_q),
    .bytes_left_i(in_left_q),
    .st_o        (st_next),
    .nres_o      (nres),
    .r0_o        (r0),
    .r1_o        (r1)
  );

  jsu_outq u_outq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .r0_i  (r0),
    .r1_i  (r1),
    .pop_i (m_axis_tready),
    .room_o(room),
    .vld_o (m_axis_tvalid),
    .head_o(head)
  );

  // Advance the held byte when its results fit in the queue
  assign go            = in_vld_q && (nres <= room);
  assign push          = go ? nres : 2'd0;
  assign s_axis_tready = !in_vld_q || go;
  assign s_xfer        = s_axis_tvalid && s_axis_tready;
  assign in_vld_d      = s_xfer || (in_vld_q && !go);

  assign m_axis_tdata = head.out_byte;
  assign m_axis_tuser = {head.status, head.done_res, head.byte_valid};
  assign m_axis_tlast = head.last;

  // Input stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Input stage payload
  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_left_q <= s_axis_tdata[23:8];
    end
  end

  // Capacity register and parse state; a capacity write reloads the space
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= jsu_pkg::CapReset;
      st_q  <= '{mode: jsu_pkg::MODE_PLAIN, hex_cnt: 2'd0, hex_acc: 12'h000,
                 space: jsu_pkg::CapReset};
    end else if (cfg_we_i) begin
      cap_q      <= cfg_wdata_i;
      st_q.space <= cfg_wdata_i;
    end else if (go) begin
      st_q <= st_next;
    end
  end

endmodule

// File: src/jsu_step.sv
// Combinational step of the unescaper: one source byte plus the parse state
// give up to two results and the next state. Depends on jsu_pkg.
module jsu_step (
  input  jsu_pkg::state_t             st_i,
  input  logic [jsu_pkg::LenW-1:0]    cap_i,
  input  logic [7:0]                  in_byte_i,
  input  logic [jsu_pkg::LenW-1:0]    bytes_left_i,
  output jsu_pkg::state_t             st_o,
  output logic [1:0]                  nres_o,
  output jsu_pkg::res_t               r0_o,
  output jsu_pkg::res_t               r1_o
);

  function automatic jsu_pkg::res_t fin_res(jsu_pkg::status_e s);
    jsu_pkg::res_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b0;
    r.done_res   = 1'b1;
    r.status     = s;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic jsu_pkg::res_t byte_res(logic [7:0] b, logic lst);
    jsu_pkg::res_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.done_res   = 1'b0;
    r.status     = jsu_pkg::ST_OK;
    r.last       = lst;
    return r;
  endfunction

  jsu_pkg::state_t restart_st;
  logic [4:0]      hexd;
  logic [15:0]     code;
  logic [jsu_pkg::LenW-1:0] sp_dec;

  assign restart_st = '{mode: jsu_pkg::MODE_PLAIN, hex_cnt: 2'd0, hex_acc: 12'h000,
                        space: cap_i};
  assign hexd   = jsu_pkg::hex_value(in_byte_i);
  assign code   = {st_i.hex_acc, hexd[3:0]};
  assign sp_dec = st_i.space - jsu_pkg::LenW'(1);

  // Decode one byte against the current mode
  always_comb begin
    st_o   = st_i;
    nres_o = 2'd0;
    r0_o   = '0;
    r1_o   = '0;
    if (bytes_left_i == '0) begin
      r0_o = fin_res(jsu_pkg::ST_NOINPUT); nres_o = 2'd1; st_o = restart_st;
    end else begin
      unique case (st_i.mode)
        jsu_pkg::MODE_ESC: begin
          if (in_byte_i == jsu_pkg::ChU) begin
            if (bytes_left_i < jsu_pkg::MinHexLeft) begin
              r0_o = fin_res(jsu_pkg::ST_NOINPUT); nres_o = 2'd1; st_o = restart_st;
            end else begin
              st_o.mode    = jsu_pkg::MODE_HEX;
              st_o.hex_cnt = 2'd0;
              st_o.hex_acc = 12'h000;
            end
          end else if (st_i.space == '0) begin
            r0_o = fin_res(jsu_pkg::ST_NOMEM); nres_o = 2'd1; st_o = restart_st;
          end else begin
            r0_o = byte_res(in_byte_i, 1'b1); nres_o = 2'd1;
            st_o.mode  = jsu_pkg::MODE_PLAIN;
            st_o.space = sp_dec;
          end
        end
        jsu_pkg::MODE_HEX: begin
          if (hexd[4]) begin
            r0_o = fin_res(jsu_pkg::ST_MALFORMED); nres_o = 2'd1; st_o = restart_st;
          end else if (st_i.hex_cnt != 2'd3) begin
            st_o.hex_acc = {st_i.hex_acc[7:0], hexd[3:0]};
            st_o.hex_cnt = st_i.hex_cnt + 2'd1;
          end else if (st_i.space == '0) begin
            // no room even for the first byte of the code
            r0_o = fin_res(jsu_pkg::ST_NOMEM); nres_o = 2'd1; st_o = restart_st;
          end else if (code[15:8] != 8'h00) begin
            r0_o   = byte_res(code[15:8], 1'b0);
            nres_o = 2'd2;
            if (sp_dec == '0) begin
              // high byte fits, low byte does not
              r1_o = fin_res(jsu_pkg::ST_NOMEM); st_o = restart_st;
            end else begin
              r1_o = byte_res(code[7:0], 1'b1);
              st_o = '{mode: jsu_pkg::MODE_PLAIN, hex_cnt: 2'd0, hex_acc: 12'h000,
                       space: sp_dec - jsu_pkg::LenW'(1)};
            end
          end else begin
            r0_o = byte_res(code[7:0], 1'b1); nres_o = 2'd1;
            st_o = '{mode: jsu_pkg::MODE_PLAIN, hex_cnt: 2'd0, hex_acc: 12'h000,
                     space: sp_dec};
          end
        end
        default: begin
          if (in_byte_i == jsu_pkg::ChQuote) begin
            if (st_i.space != '0) begin
              r0_o = fin_res(jsu_pkg::ST_OK);
            end else begin
              r0_o = fin_res(jsu_pkg::ST_NOMEM);
            end
            nres_o = 2'd1; st_o = restart_st;
          end else if (in_byte_i == jsu_pkg::ChNul) begin
            r0_o = fin_res(jsu_pkg::ST_MALFORMED); nres_o = 2'd1; st_o = restart_st;
          end else if (in_byte_i == jsu_pkg::ChBslash) begin
            if (bytes_left_i == jsu_pkg::LenW'(1)) begin
              r0_o = fin_res(jsu_pkg::ST_NOINPUT); nres_o = 2'd1; st_o = restart_st;
            end else begin
              st_o.mode = jsu_pkg::MODE_ESC;
            end
          end else if (st_i.space == '0) begin
            r0_o = fin_res(jsu_pkg::ST_NOMEM); nres_o = 2'd1; st_o = restart_st;
          end else begin
            r0_o = byte_res(in_byte_i, 1'b1); nres_o = 2'd1;
            st_o.space = sp_dec;
          end
        end
      endcase
    end
  end

endmodule

// File: src/jsu_outq.sv
// Two-entry result queue between the step logic and the output stream.
// Depends on jsu_pkg.
module jsu_outq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [1:0]    push_i,
  input  jsu_pkg::res_t r0_i,
  input  jsu_pkg::res_t r1_i,
  input  logic          pop_i,
  output logic [1:0]    room_o,
  output logic          vld_o,
  output jsu_pkg::res_t head_o
);

  jsu_pkg::res_t ent_q [2];
  jsu_pkg::res_t ent_d [2];
  logic [1:0]    cnt_q, cnt_d, cnt_pop;

  assign vld_o   = (cnt_q != 2'd0);
  assign head_o  = ent_q[0];
  assign cnt_pop = (pop_i && vld_o) ? cnt_q - 2'd1 : cnt_q;
  assign room_o  = 2'd2 - cnt_pop;

  // Shift out on pop, then append pushed results behind what remains
  always_comb begin
    ent_d[0] = (pop_i && vld_o) ? ent_q[1] : ent_q[0];
    ent_d[1] = ent_q[1];
    if (push_i != 2'd0) begin
      ent_d[cnt_pop[0]] = r0_i;
    end
    if (push_i == 2'd2) begin
      ent_d[1] = r1_i;
    end
    cnt_d = cnt_pop + push_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q[0] <= ent_d[0];
    ent_q[1] <= ent_d[1];
  end

endmodule

// File: dv/tb_json_string_unescaper_unit.sv
// Self-checking testbench for json_string_unescaper_unit: stream driver, monitor and predictor.
// Depends on jsu_pkg and json_string_unescaper_unit; needs no files or arguments.
`timescale 1ns / 1ps

module tb_json_string_unescaper_unit;
  import jsu_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned PHASE_BYTES   = 340;

  // One source byte with the count of source bytes still available
  typedef struct packed {
    logic [LenW-1:0] avail;
    logic [7:0]      ch;
  } src_item_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            cfg_we_i = 1'b0;
  logic [15:0]     cfg_wdata_i = '0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [23:0]     s_axis_tdata = '0;   // [7:0] in_byte, [23:8] bytes_left
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [7:0]      m_axis_tdata;        // [7:0] out_byte
  logic [3:0]      m_axis_tuser;        // [0] byte_valid, [1] done_res, [3:2] status
  logic            m_axis_tlast;

  // Predicted unescaper state
  mode_e           unesc_mode = MODE_PLAIN;
  logic [1:0]      hex_cnt = '0;
  logic [11:0]     hex_acc = '0;
  logic [LenW-1:0] space_left = CapReset;
  logic [LenW-1:0] dest_capacity = CapReset;

  src_item_t       source_q[$];
  res_t            unescaped_q[$];
  int unsigned     source_queued = 0;
  int unsigned     source_taken = 0;
  bit              src_beat_taken = 1'b0;
  int unsigned     src_idle_pct = 19;
  int unsigned     snk_idle_pct = 47;
  int unsigned     hold_left = 0;
  bit              long_hold_done = 1'b0;
  int unsigned     quiet_cycles = 0;
  int unsigned     fail_count = 0;

  json_string_unescaper_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Hex digit value, or -1 for any other byte
  function automatic int hex_digit(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c - 8'h30);
    if (c >= 8'h41 && c <= 8'h46) return int'(c - 8'h41) + 10;
    if (c >= 8'h61 && c <= 8'h66) return int'(c - 8'h61) + 10;
    return -1;
  endfunction

  // Random hex digit in either letter case
  function automatic logic [7:0] hex_char();
    int unsigned d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'(8'h30 + d);
    return 8'(($urandom_range(0, 1) ? 8'h61 : 8'h41) + d - 10);
  endfunction

  // End the string with a status and start over with a full destination
  task automatic end_string(status_e st);
    unescaped_q.push_back('{out_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1,
                            status: st, last: 1'b1});
    unesc_mode = MODE_PLAIN;
    hex_cnt    = '0;
    hex_acc    = '0;
    space_left = dest_capacity;
  endtask

  // Write one destination byte, or end with out of memory when full
  task automatic write_byte(logic [7:0] b, logic last_flag);
    if (space_left == 0) begin
      end_string(ST_NOMEM);
    end else begin
      space_left--;
      unescaped_q.push_back('{out_byte: b, byte_valid: 1'b1, done_res: 1'b0,
                              status: ST_OK, last: last_flag});
    end
  endtask

  // Advance the unescaper by one source byte and queue what it writes
  task automatic unescape_step(logic [7:0] c, logic [LenW-1:0] n);
    int d;
    logic [15:0] code;
    if (n == 0) begin
      end_string(ST_NOINPUT);
    end else begin
      case (unesc_mode)
        MODE_ESC: begin
          if (c == ChU) begin
            // four digits must still fit in the source
            if (n < MinHexLeft) begin
              end_string(ST_NOINPUT);
            end else begin
              unesc_mode = MODE_HEX;
              hex_cnt    = '0;
              hex_acc    = '0;
            end
          end else begin
            unesc_mode = MODE_PLAIN;
            write_byte(c, 1'b1);
          end
        end
        MODE_HEX: begin
          d = hex_digit(c);
          if (d < 0) begin
            end_string(ST_MALFORMED);
          end else if (hex_cnt != 2'd3) begin
            hex_acc = {hex_acc[7:0], 4'(d)};
            hex_cnt++;
          end else begin
            code       = {hex_acc, 4'(d)};
            unesc_mode = MODE_PLAIN;
            hex_cnt    = '0;
            hex_acc    = '0;
            if (code[15:8] == 8'h00) begin
              write_byte(code[7:0], 1'b1);
            end else if (space_left == 0) begin
              end_string(ST_NOMEM);
            end else begin
              // high byte first; the low byte may still run out of space
              write_byte(code[15:8], 1'b0);
              write_byte(code[7:0], 1'b1);
            end
          end
        end
        default: begin
          if (c == ChQuote) begin
            if (space_left != 0) begin
              end_string(ST_OK);
            end else begin
              end_string(ST_NOMEM);
            end
          end else if (c == ChNul) begin
            end_string(ST_MALFORMED);
          end else if (c == ChBslash) begin
            if (n == 1) begin
              end_string(ST_NOINPUT);
            end else begin
              unesc_mode = MODE_ESC;
            end
          end else begin
            write_byte(c, 1'b1);
          end
        end
      endcase
    end
  endtask

  // Compare one output transfer with the oldest predicted result
  task automatic check_result();
    res_t got;
    res_t want;
    got = '{out_byte: m_axis_tdata, byte_valid: m_axis_tuser[0], done_res: m_axis_tuser[1],
            status: status_e'(m_axis_tuser[3:2]), last: m_axis_tlast};
    if (unescaped_q.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("unexpected result: byte=%02h valid=%0b done=%0b status=%0d last=%0b",
                 got.out_byte, got.byte_valid, got.done_res, got.status, got.last);
      end
    end else begin
      want = unescaped_q.pop_front();
      if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid ||
          got.done_res !== want.done_res || got.status !== want.status ||
          got.last !== want.last) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("mismatch: expected byte=%02h valid=%0b done=%0b status=%0d last=%0b",
                   want.out_byte, want.byte_valid, want.done_res, want.status, want.last);
          $display("          got      byte=%02h valid=%0b done=%0b status=%0d last=%0b",
                   got.out_byte, got.byte_valid, got.done_res, got.status, got.last);
        end
      end
    end
  endtask

  task automatic queue_byte(logic [7:0] c, logic [LenW-1:0] n);
    source_q.push_back('{avail: n, ch: c});
    source_queued++;
  endtask

  // Build one string body with random content, mostly well formed
  task automatic queue_random_string();
    logic [7:0]  body[$];
    logic [7:0]  c;
    int unsigned pick;
    int unsigned start_left;
    repeat ($urandom_range(0, 10)) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        do c = 8'($urandom_range(1, 255)); while (c == ChQuote || c == ChBslash);
        body.push_back(c);
      end else if (pick < 72) begin
        c = 8'($urandom);
        body.push_back(ChBslash);
        body.push_back((c == ChU) ? ChQuote : c);
      end else if (pick < 92) begin
        body.push_back(ChBslash);
        body.push_back(ChU);
        repeat (4) body.push_back(hex_char());
      end else if (pick < 96) begin
        // unicode escape broken by a byte that is no hex digit
        body.push_back(ChBslash);
        body.push_back(ChU);
        repeat ($urandom_range(0, 3)) body.push_back(hex_char());
        do c = 8'($urandom); while (hex_digit(c) >= 0);
        body.push_back(c);
      end else begin
        body.push_back($urandom_range(0, 1) ? ChNul : 8'($urandom));
      end
    end
    if ($urandom_range(0, 9) != 0) body.push_back(ChQuote);
    // count down the available source; sometimes let it run dry
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      start_left = $urandom_range(body.size(), 65535);
    end else if (pick == 1) begin
      start_left = $urandom_range(0, body.size());
    end else begin
      start_left = body.size() + $urandom_range(0, 30);
    end
    foreach (body[idx]) begin
      queue_byte(body[idx], (start_left > idx) ? LenW'(start_left - idx) : LenW'(0));
    end
  endtask

  // Hold until every byte is taken and every result is out, then let the pipe settle
  task automatic wait_drained();
    @(negedge clk_i);
    while (source_taken != source_queued || unescaped_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capacity(logic [LenW-1:0] value);
    @(negedge clk_i);
    cfg_wdata_i   <= value;
    cfg_we_i      <= 1'b1;
    dest_capacity = value;
    space_left    = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic run_random_phase(int unsigned goal);
    int unsigned first;
    first = source_queued;
    while (source_queued - first < goal) begin
      if ($urandom_range(0, 99) < 8) begin
        queue_byte(8'($urandom), ($urandom_range(0, 3) == 0) ? LenW'(0) : LenW'($urandom));
      end else begin
        queue_random_string();
      end
    end
    wait_drained();
  endtask

  // Source driver: offer the next byte at the falling edge, hold until taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || src_beat_taken)) begin
      src_beat_taken = 1'b0;
      if (source_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
        s_axis_tdata  <= source_q.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result sink: random back-pressure, plus one long hold to fill the block
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && snk_idle_pct == 0 &&
                   source_queued - source_taken > 100) begin
        long_hold_done = 1'b1;
        hold_left      = LONG_HOLD - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // Monitor: predict on each source transfer, check each result transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        unescape_step(s_axis_tdata[7:0], s_axis_tdata[23:8]);
        src_beat_taken = 1'b1;
        source_taken++;
      end
      if (m_axis_tvalid && m_axis_tready) check_result();
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset capacity: plain, close, zero byte, backslash at the end of the source
    queue_byte(8'hFF, 16'hFFFF);
    queue_byte(ChQuote, 16'd40);
    queue_byte(ChNul, 16'd40);
    queue_byte(ChBslash, 16'd1);
    // escaped zero is written as data
    queue_byte(ChBslash, 16'd9);
    queue_byte(ChNul, 16'd8);
    // unicode escape with too few bytes left
    queue_byte(ChBslash, 16'd5);
    queue_byte(ChU, 16'd4);
    // unicode escape with a zero high byte: "0041"
    queue_byte(ChBslash, 16'd7);
    queue_byte(ChU, 16'd6);
    queue_byte(8'h30, 16'd5);
    queue_byte(8'h30, 16'd4);
    queue_byte(8'h34, 16'd3);
    queue_byte(8'h31, 16'd2);
    // bad hex digit 'G'
    queue_byte(ChBslash, 16'd9);
    queue_byte(ChU, 16'd8);
    queue_byte(8'h47, 16'd7);
    // source exhausted after a backslash
    queue_byte(ChBslash, 16'd3);
    queue_byte(8'hAA, 16'd0);
    wait_drained();

    // One byte of space: high byte of "4aB2" fits, the low byte does not
    write_capacity(16'd1);
    queue_byte(ChBslash, 16'd20);
    queue_byte(ChU, 16'd19);
    queue_byte(8'h34, 16'd18);
    queue_byte(8'h61, 16'd17);
    queue_byte(8'h42, 16'd16);
    queue_byte(8'h32, 16'd15);
    wait_drained();

    // No space: close and a two-byte escape "fF01" both run out of memory
    write_capacity(16'd0);
    queue_byte(ChQuote, 16'd30);
    queue_byte(ChBslash, 16'd29);
    queue_byte(ChU, 16'd28);
    queue_byte(8'h66, 16'd27);
    queue_byte(8'h46, 16'd26);
    queue_byte(8'h30, 16'd25);
    queue_byte(8'h31, 16'd24);
    wait_drained();

    write_capacity(16'd16);
    run_random_phase(PHASE_BYTES);

    src_idle_pct = 47;
    snk_idle_pct = 19;
    write_capacity(16'hFFFF);
    run_random_phase(PHASE_BYTES);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_capacity(LenW'($urandom_range(3, 40)));
    run_random_phase(PHASE_BYTES);

    if (fail_count == 0 && unescaped_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: json_string_unescaper_unit.f
src/jsu_pkg.sv
src/jsu_step.sv
src/jsu_outq.sv
src/json_string_unescaper_unit.sv
dv/tb_json_string_unescaper_unit.sv
